// File: design/e2q_pkg.sv
// Package for the Euler-to-quaternion pipeline: field widths, stream widths,
// the CORDIC gain and arctangent table, and the clamp limit for angles.
// No dependencies.
package e2q_pkg;

	localparam int ANGLE_WIDTH  = 16;
	localparam int RESULT_WIDTH = 16;
	localparam int ANGLE_FRAC   = ANGLE_WIDTH - 3;

	localparam int IN_BYTES   = (3 * ANGLE_WIDTH + 7) / 8;
	localparam int OUT_BYTES  = (4 * RESULT_WIDTH + 7) / 8;
	localparam int IN_TDATA_W  = IN_BYTES * 8;
	localparam int OUT_TDATA_W = OUT_BYTES * 8;

	localparam int CORDIC_STEPS = 30;
	localparam int CW = 32;	// CORDIC datapath width, Q2.30
	localparam int PW = 64;	// product width

	localparam logic [63:0] PI_Q61 = 64'h6487ED5110B4611A;
	localparam logic [63:0] PI_Q_FULL =
		(PI_Q61 + (64'd1 << (60 - ANGLE_FRAC))) >> (61 - ANGLE_FRAC);
	localparam logic signed [ANGLE_WIDTH:0] PI_Q = PI_Q_FULL[ANGLE_WIDTH:0];

	localparam logic signed [CW-1:0] CORDIC_K = 32'sd652032874;

	localparam logic signed [PW-1:0] RES_HI = (64'sd1 <<< (RESULT_WIDTH - 1)) - 64'sd1;
	localparam logic signed [PW-1:0] RES_LO = -RES_HI - 64'sd1;

	localparam int PIPE_DEPTH = CORDIC_STEPS + 5;

	typedef logic signed [CW-1:0] cval_t;
	typedef logic signed [PW-1:0] prod_t;

	function automatic cval_t atan_q30(input logic [4:0] idx);
		cval_t r;
		case (idx)
			5'd0:  r = 32'h3243F6A8;
			5'd1:  r = 32'h1DAC6705;
			5'd2:  r = 32'h0FADBAFC;
			5'd3:  r = 32'h07F56EA6;
			5'd4:  r = 32'h03FEAB76;
			5'd5:  r = 32'h01FFD55B;
			5'd6:  r = 32'h00FFFAAA;
			5'd7:  r = 32'h007FFF55;
			5'd8:  r = 32'h003FFFEA;
			5'd9:  r = 32'h001FFFFD;
			5'd10: r = 32'h000FFFFF;
			5'd11: r = 32'h0007FFFF;
			5'd12: r = 32'h0003FFFF;
			5'd13: r = 32'h0001FFFF;
			5'd14: r = 32'h0000FFFF;
			5'd15: r = 32'h00007FFF;
			5'd16: r = 32'h00003FFF;
			5'd17: r = 32'h00001FFF;
			5'd18: r = 32'h00000FFF;
			5'd19: r = 32'h000007FF;
			5'd20: r = 32'h000003FF;
			5'd21: r = 32'h000001FF;
			5'd22: r = 32'h000000FF;
			5'd23: r = 32'h0000007F;
			5'd24: r = 32'h0000003F;
			5'd25: r = 32'h0000001F;
			5'd26: r = 32'h0000000F;
			5'd27: r = 32'h00000008;
			5'd28: r = 32'h00000004;
			5'd29: r = 32'h00000002;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// File: design/euler_angles_to_quaternion.sv
// Euler ZYX angles to unit quaternion: clamp, 30-step CORDIC per angle,
// two multiply rounds, round-to-nearest and saturate to Q1.14.
// Depends on e2q_pkg.
//
// Throughput: one word per cycle while the output is not stalled; each
// CORDIC iteration and each multiply round is its own register stage,
// and the whole pipe advances together.
// Reset (arst_n low, asynchronous) clears every stage valid bit; payload
// registers are not reset.
module euler_angles_to_quaternion
	import e2q_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// roll_angle, pitch_angle, yaw_angle from bit 0 up, zero padded
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// quat_w, quat_x, quat_y, quat_z from bit 0 up, zero padded
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	// Whole pipe advances when the output slot is empty or being taken.
	logic adv;
	logic [PIPE_DEPTH-1:0] vld_q;

	assign adv           = !vld_q[PIPE_DEPTH-1] || m_axis_tready;
	assign s_axis_tready = adv;
	assign m_axis_tvalid = vld_q[PIPE_DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[PIPE_DEPTH-2:0], s_axis_tvalid};
		end
	end

	// Stage 1: clamp to +-pi, read as half angle, move to Q30.
	cval_t cz_s [0:CORDIC_STEPS][3];
	cval_t cx_s [0:CORDIC_STEPS][3];
	cval_t cy_s [0:CORDIC_STEPS][3];

	for (genvar a = 0; a < 3; a++) begin : g_in
		logic signed [ANGLE_WIDTH-1:0] raw;
		logic signed [ANGLE_WIDTH:0]   ext, clp;
		assign raw = s_axis_tdata[a*ANGLE_WIDTH +: ANGLE_WIDTH];
		assign ext = {raw[ANGLE_WIDTH-1], raw};
		always_comb begin
			clp = ext;
			if (ext > PI_Q)
				clp = PI_Q;
			if (ext < -PI_Q)
				clp = -PI_Q;
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				cz_s[0][a] <= cval_t'({{(CW-ANGLE_WIDTH-1){clp[ANGLE_WIDTH]}}, clp})
					<<< (29 - ANGLE_FRAC);
				cx_s[0][a] <= CORDIC_K;
				cy_s[0][a] <= '0;
			end
		end
	end

	// Stages 2..31: one CORDIC rotation per stage, all three angles in lanes.
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		for (genvar a = 0; a < 3; a++) begin : g_lane
			always_ff @(posedge clk) begin
				if (adv) begin
					if (!cz_s[i][a][CW-1]) begin
						cx_s[i+1][a] <= cx_s[i][a] - (cy_s[i][a] >>> i);
						cy_s[i+1][a] <= cy_s[i][a] + (cx_s[i][a] >>> i);
						cz_s[i+1][a] <= cz_s[i][a] - atan_q30(5'(i));
					end else begin
						cx_s[i+1][a] <= cx_s[i][a] + (cy_s[i][a] >>> i);
						cy_s[i+1][a] <= cy_s[i][a] - (cx_s[i][a] >>> i);
						cz_s[i+1][a] <= cz_s[i][a] + atan_q30(5'(i));
					end
				end
			end
		end
	end

	// Lane 0 roll, 1 pitch, 2 yaw.
	cval_t cr, sr, cp, sp, cy, sy;
	assign cr = cx_s[CORDIC_STEPS][0];
	assign sr = cy_s[CORDIC_STEPS][0];
	assign cp = cx_s[CORDIC_STEPS][1];
	assign sp = cy_s[CORDIC_STEPS][1];
	assign cy = cx_s[CORDIC_STEPS][2];
	assign sy = cy_s[CORDIC_STEPS][2];

	// Stage 32: raw pair products; carry yaw sine/cosine along.
	prod_t crcp_s32, srsp_s32, srcp_s32, crsp_s32;
	cval_t cy_s32, sy_s32, cy_s33, sy_s33;
	always_ff @(posedge clk) begin
		if (adv) begin
			crcp_s32 <= prod_t'(cr) * prod_t'(cp);
			srsp_s32 <= prod_t'(sr) * prod_t'(sp);
			srcp_s32 <= prod_t'(sr) * prod_t'(cp);
			crsp_s32 <= prod_t'(cr) * prod_t'(sp);
			cy_s32   <= cy;
			sy_s32   <= sy;
		end
	end

	// Stage 33: round pair products half up back to Q30.
	function automatic cval_t rnd30(input prod_t p);
		prod_t t;
		t = (p + (64'sd1 <<< 29)) >>> 30;
		return t[CW-1:0];
	endfunction

	cval_t crcp_s33, srsp_s33, srcp_s33, crsp_s33;
	always_ff @(posedge clk) begin
		if (adv) begin
			crcp_s33 <= rnd30(crcp_s32);
			srsp_s33 <= rnd30(srsp_s32);
			srcp_s33 <= rnd30(srcp_s32);
			crsp_s33 <= rnd30(crsp_s32);
			cy_s33   <= cy_s32;
			sy_s33   <= sy_s32;
		end
	end

	// Stage 34: the eight triple products at Q60.
	prod_t p_s34 [8];
	always_ff @(posedge clk) begin
		if (adv) begin
			p_s34[0] <= prod_t'(crcp_s33) * prod_t'(cy_s33);
			p_s34[1] <= prod_t'(srsp_s33) * prod_t'(sy_s33);
			p_s34[2] <= prod_t'(srcp_s33) * prod_t'(cy_s33);
			p_s34[3] <= prod_t'(crsp_s33) * prod_t'(sy_s33);
			p_s34[4] <= prod_t'(crsp_s33) * prod_t'(cy_s33);
			p_s34[5] <= prod_t'(srcp_s33) * prod_t'(sy_s33);
			p_s34[6] <= prod_t'(crcp_s33) * prod_t'(sy_s33);
			p_s34[7] <= prod_t'(srsp_s33) * prod_t'(cy_s33);
		end
	end

	// Stage 35: sum, round half up to the result grid, saturate.
	function automatic logic [RESULT_WIDTH-1:0] finish(input prod_t v);
		prod_t r;
		r = (v + (64'sd1 <<< (61 - RESULT_WIDTH))) >>> (62 - RESULT_WIDTH);
		if (r > RES_HI)
			r = RES_HI;
		if (r < RES_LO)
			r = RES_LO;
		return r[RESULT_WIDTH-1:0];
	endfunction

	logic [RESULT_WIDTH-1:0] qw_s35, qx_s35, qy_s35, qz_s35;
	always_ff @(posedge clk) begin
		if (adv) begin
			qw_s35 <= finish(p_s34[0] + p_s34[1]);
			qx_s35 <= finish(p_s34[2] - p_s34[3]);
			qy_s35 <= finish(p_s34[4] + p_s34[5]);
			qz_s35 <= finish(p_s34[6] - p_s34[7]);
		end
	end

	assign m_axis_tdata = {{(OUT_TDATA_W - 4*RESULT_WIDTH){1'b0}},
		qz_s35, qy_s35, qx_s35, qw_s35};

endmodule

// File: design/e2q_checker.sv
// Port-level checks for euler_angles_to_quaternion, bound to the top level.
// Depends on e2q_pkg.
module e2q_checker
	import e2q_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	// Hold a stalled output word.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output word changed under stall");

	// An empty output slot never blocks the input.
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

	// A consumer that takes every word never stalls the input.
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input stalled while output drains");

	// Padding bits stay zero.
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata >> (4*RESULT_WIDTH)) == '0)
		else $error("nonzero padding in output word");

endmodule

bind euler_angles_to_quaternion e2q_checker u_e2q_checker (.*);
